// ===== hdl/hex_text_to_bytes_parser_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Hex text parser assertion macros
// Shared macros for the concurrent checks of the hex text parser.
// ----------------------------------------------------------------------------
`ifndef HEX_TEXT_TO_BYTES_PARSER_UNIT_ASSERT_SVH
`define HEX_TEXT_TO_BYTES_PARSER_UNIT_ASSERT_SVH

// Antecedent holds in a cycle, so the consequent holds in the same cycle.
`define HP_ASSERT_SAME(lbl, clock, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent holds in a cycle, so the consequent holds in the next cycle.
`define HP_ASSERT_NEXT(lbl, clock, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/hexparse_pkg.sv =====
// ----------------------------------------------------------------------------
// Hex text parser package
// Types and character constants shared by the parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hexparse_pkg;

	// Parse phase of the current string.
	typedef enum logic [1:0] {
		PH_LEAD = 2'd0,
		PH_ZERO = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	// Error and final status codes.
	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_BAD = 2'd1,
		ST_OVF = 2'd2
	} status_t;

	// Kind of a result item.
	typedef enum logic {
		KIND_BYTE   = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_HYPHEN  = 8'h2D;
	localparam logic [7:0] CH_LOWER_X = 8'h78;
	localparam logic [7:0] CH_UPPER_X = 8'h58;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] ALPHA_BASE = 8'd10;

	localparam int unsigned COUNT_W = 16;

	// Decoder state kept between characters.
	typedef struct packed {
		phase_t             phase;
		logic [3:0]         pending_nibble;
		logic               nibble_held;
		logic [COUNT_W-1:0] bytes_done;
		status_t            first_error;
	} parse_state_t;

	// One result item.
	typedef struct packed {
		kind_t              kind;
		logic [7:0]         byte_value;
		status_t            status;
		logic [COUNT_W-1:0] byte_count;
	} result_t;

	localparam parse_state_t STATE_RESET = '{
		phase:          PH_LEAD,
		pending_nibble: 4'd0,
		nibble_held:    1'b0,
		bytes_done:     '0,
		first_error:    ST_OK
	};

endpackage

// ===== hdl/hexparse_step.sv =====
// ----------------------------------------------------------------------------
// Hex text parser step logic
// Combinational next-state and result logic for one character or end item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hexparse_step (
	input  hexparse_pkg::parse_state_t                cur,
	input  logic [7:0]                                char_code,
	input  logic                                      end_of_text,
	input  logic [hexparse_pkg::COUNT_W-1:0]          max_bytes,
	output hexparse_pkg::parse_state_t                nxt,
	output logic                                      emit,
	output hexparse_pkg::result_t                     res
);

	logic       is_space;
	logic       is_delim;
	logic       is_hex;
	logic [3:0] hex_val;
	logic       body_go;

	// Character classification.
	always_comb begin
		is_space = (char_code inside {[hexparse_pkg::CH_TAB:hexparse_pkg::CH_CR],
			hexparse_pkg::CH_SPACE});
		is_delim = is_space || (char_code == hexparse_pkg::CH_COLON)
			|| (char_code == hexparse_pkg::CH_HYPHEN);
		is_hex  = 1'b1;
		hex_val = 4'd0;
		case (char_code) inside
			[8'h30:8'h39]: hex_val = char_code[3:0];
			[8'h61:8'h66]: hex_val = 4'(char_code - hexparse_pkg::CH_LOWER_A
				+ hexparse_pkg::ALPHA_BASE);
			[8'h41:8'h46]: hex_val = 4'(char_code - hexparse_pkg::CH_UPPER_A
				+ hexparse_pkg::ALPHA_BASE);
			default: is_hex = 1'b0;
		endcase
	end

	// Phase handling, body decoding and the end-of-text report.
	always_comb begin
		nxt     = cur;
		emit    = 1'b0;
		body_go = 1'b0;
		res     = '{kind: hexparse_pkg::KIND_BYTE, byte_value: 8'd0,
			status: hexparse_pkg::ST_OK, byte_count: '0};

		if (end_of_text) begin
			emit        = 1'b1;
			res.kind    = hexparse_pkg::KIND_STATUS;
			res.status  = cur.first_error;
			if ((cur.first_error == hexparse_pkg::ST_OK) && cur.nibble_held) begin
				res.status = hexparse_pkg::ST_BAD;
			end
			res.byte_count = (res.status == hexparse_pkg::ST_OK) ? cur.bytes_done : '0;
			nxt = hexparse_pkg::STATE_RESET;
		end else if (cur.first_error == hexparse_pkg::ST_OK) begin
			case (cur.phase)
				hexparse_pkg::PH_LEAD: begin
					if (is_space) begin
						nxt.phase = hexparse_pkg::PH_LEAD;
					end else if (char_code == hexparse_pkg::CH_ZERO) begin
						nxt.pending_nibble = 4'd0;
						nxt.nibble_held    = 1'b1;
						nxt.phase          = hexparse_pkg::PH_ZERO;
					end else begin
						nxt.phase = hexparse_pkg::PH_BODY;
						body_go   = 1'b1;
					end
				end
				hexparse_pkg::PH_ZERO: begin
					nxt.phase = hexparse_pkg::PH_BODY;
					if ((char_code == hexparse_pkg::CH_LOWER_X)
						|| (char_code == hexparse_pkg::CH_UPPER_X)) begin
						nxt.nibble_held    = 1'b0;
						nxt.pending_nibble = 4'd0;
					end else begin
						body_go = 1'b1;
					end
				end
				default: begin
					body_go = 1'b1;
				end
			endcase

			// Body: skip delimiters, pair digits into bytes.
			if (body_go && !is_delim) begin
				if (!is_hex) begin
					nxt.first_error = hexparse_pkg::ST_BAD;
				end else if (!cur.nibble_held) begin
					nxt.pending_nibble = hex_val;
					nxt.nibble_held    = 1'b1;
				end else begin
					nxt.nibble_held = 1'b0;
					if (cur.bytes_done >= max_bytes) begin
						nxt.first_error = hexparse_pkg::ST_OVF;
					end else begin
						nxt.bytes_done = cur.bytes_done + 1'b1;
						emit           = 1'b1;
						res.byte_value = {cur.pending_nibble, hex_val};
						res.byte_count = cur.bytes_done + 1'b1;
					end
				end
			end
		end
	end

endmodule

// ===== hdl/hex_text_to_bytes_parser_unit.sv =====
// ----------------------------------------------------------------------------
// Hex text to bytes parser
// Decodes an ASCII hex string, one character per transfer, into bytes.
// ----------------------------------------------------------------------------
// The parser gives each decoded byte, and the final status for an end-of-text
// transfer, after its character has passed the input register and the result
// register. Throughput is one character per cycle; it drops only while a
// finished result waits in the result register and the next character would
// produce another result.
// max_bytes is written through cfg_we/cfg_wdata; the user must write it only
// while no string is in flight, as the block itself does not enforce this.
`timescale 1ns / 1ps
`include "hex_text_to_bytes_parser_unit_assert.svh"

module hex_text_to_bytes_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: max_bytes.
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	// Character stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,   // end_of_text
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] byte_value, [9:8] status, [25:10] byte_count
	output logic        m_tuser    // result_kind
);

	logic [hexparse_pkg::COUNT_W-1:0] max_bytes_q;
	hexparse_pkg::parse_state_t       state_q;
	hexparse_pkg::parse_state_t       state_nxt;
	hexparse_pkg::result_t            res;
	hexparse_pkg::result_t            res_s2;
	logic                             emit;
	logic                             valid_s1;
	logic [7:0]                       char_s1;
	logic                             end_s1;
	logic                             valid_s2;
	logic                             proceed;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= '1;
		end else if (cfg_we) begin
			max_bytes_q <= cfg_wdata;
		end
	end

	// The held item is processed unless it produces a result that cannot be stored.
	assign proceed  = valid_s1 && (!emit || !valid_s2 || m_tready);
	assign s_tready = !valid_s1 || proceed;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			end_s1  <= s_tlast;
		end
	end

	hexparse_step u_step (
		.cur         (state_q),
		.char_code   (char_s1),
		.end_of_text (end_s1),
		.max_bytes   (max_bytes_q),
		.nxt         (state_nxt),
		.emit        (emit),
		.res         (res)
	);

	// Decoder state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hexparse_pkg::STATE_RESET;
		end else if (proceed) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (proceed && emit) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proceed && emit) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.kind;
	assign m_tdata  = {6'd0, res_s2.byte_count, res_s2.status, res_s2.byte_value};

	// An end item leaves the decoder in its reset state.
	`HP_ASSERT_NEXT(a_end_clears, clk, arst_n, proceed && end_s1,
		state_q == hexparse_pkg::STATE_RESET, "decoder state not cleared after end item")

	// No byte is produced once an error has been recorded.
	`HP_ASSERT_SAME(a_err_blocks, clk, arst_n,
		proceed && emit && (res.kind == hexparse_pkg::KIND_BYTE),
		state_q.first_error == hexparse_pkg::ST_OK, "byte produced after an error")

	// A byte is produced only below the configured limit.
	`HP_ASSERT_SAME(a_limit, clk, arst_n,
		proceed && emit && (res.kind == hexparse_pkg::KIND_BYTE),
		state_q.bytes_done < max_bytes_q, "byte produced past max_bytes")

	// A failed string reports a zero count.
	`HP_ASSERT_SAME(a_err_count, clk, arst_n,
		valid_s2 && (res_s2.kind == hexparse_pkg::KIND_STATUS)
			&& (res_s2.status != hexparse_pkg::ST_OK),
		res_s2.byte_count == '0, "nonzero count reported with an error status")

endmodule

// ===== test/hex_parse_checker.sv =====
// ----------------------------------------------------------------------------
// Hex text parser checker
// Watches the character, result and configuration ports of the parser, keeps
// its own copy of the decoder state, and compares every result transfer with
// the oldest predicted result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hex_parse_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,   // end_of_text
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [7:0] byte_value, [9:8] status, [25:10] byte_count
	input  logic        m_tuser,   // result_kind
	output int          fail_count,
	output int          pending,
	output int          bytes_seen,
	output int          status_seen
);

	// Shadow of the decoder state and the byte limit.
	hexparse_pkg::phase_t  phase;
	logic [3:0]            held_nibble;
	logic                  nibble_valid;
	logic [15:0]           decoded_count;
	hexparse_pkg::status_t sticky_error;
	logic [15:0]           byte_limit;

	// Results predicted but not yet seen on the result port.
	hexparse_pkg::result_t expected_results[$];

	function automatic bit is_blank(input logic [7:0] c);
		return c == hexparse_pkg::CH_SPACE
			|| (c >= hexparse_pkg::CH_TAB && c <= hexparse_pkg::CH_CR);
	endfunction

	// Returns 1 and the digit value for a hex digit of either case.
	function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
		v = 4'd0;
		if (c >= hexparse_pkg::CH_ZERO && c <= hexparse_pkg::CH_ZERO + 8'd9) begin
			v = 4'(c - hexparse_pkg::CH_ZERO);
			return 1'b1;
		end
		if (c >= hexparse_pkg::CH_LOWER_A && c < hexparse_pkg::CH_LOWER_A + 8'd6) begin
			v = 4'(c - hexparse_pkg::CH_LOWER_A + hexparse_pkg::ALPHA_BASE);
			return 1'b1;
		end
		if (c >= hexparse_pkg::CH_UPPER_A && c < hexparse_pkg::CH_UPPER_A + 8'd6) begin
			v = 4'(c - hexparse_pkg::CH_UPPER_A + hexparse_pkg::ALPHA_BASE);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic clear_parse();
		phase = hexparse_pkg::PH_LEAD;
		held_nibble = 4'd0;
		nibble_valid = 1'b0;
		decoded_count = 16'd0;
		sticky_error = hexparse_pkg::ST_OK;
	endtask

	task automatic report_mismatch(input string what);
		fail_count++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// Body decoding of one character; a completed byte becomes a result.
	task automatic decode_body(input logic [7:0] c);
		logic [3:0]            v;
		bit                    is_hex;
		hexparse_pkg::result_t r;
		if (is_blank(c) || c == hexparse_pkg::CH_COLON || c == hexparse_pkg::CH_HYPHEN)
			return;
		is_hex = hex_digit(c, v);
		if (!is_hex) begin
			sticky_error = hexparse_pkg::ST_BAD;
			return;
		end
		if (!nibble_valid) begin
			held_nibble = v;
			nibble_valid = 1'b1;
			return;
		end
		nibble_valid = 1'b0;
		if (decoded_count >= byte_limit) begin
			sticky_error = hexparse_pkg::ST_OVF;
			return;
		end
		decoded_count = decoded_count + 16'd1;
		r.kind = hexparse_pkg::KIND_BYTE;
		r.byte_value = {held_nibble, v};
		r.status = hexparse_pkg::ST_OK;
		r.byte_count = decoded_count;
		expected_results.push_back(r);
	endtask

	// Works out what one accepted character or end transfer produces.
	task automatic predict_transfer(input logic [7:0] c, input logic last);
		hexparse_pkg::status_t st;
		hexparse_pkg::result_t r;
		if (last) begin
			st = sticky_error;
			if (st == hexparse_pkg::ST_OK && nibble_valid)
				st = hexparse_pkg::ST_BAD;
			r.kind = hexparse_pkg::KIND_STATUS;
			r.byte_value = 8'd0;
			r.status = st;
			r.byte_count = (st == hexparse_pkg::ST_OK) ? decoded_count : 16'd0;
			expected_results.push_back(r);
			clear_parse();
			return;
		end
		if (sticky_error != hexparse_pkg::ST_OK)
			return;
		case (phase)
			hexparse_pkg::PH_LEAD: begin
				if (c == hexparse_pkg::CH_ZERO) begin
					held_nibble = 4'd0;
					nibble_valid = 1'b1;
					phase = hexparse_pkg::PH_ZERO;
				end else if (!is_blank(c)) begin
					phase = hexparse_pkg::PH_BODY;
					decode_body(c);
				end
			end
			hexparse_pkg::PH_ZERO: begin
				// A leading zero is either the prefix or a real high nibble.
				phase = hexparse_pkg::PH_BODY;
				if (c == hexparse_pkg::CH_LOWER_X || c == hexparse_pkg::CH_UPPER_X) begin
					nibble_valid = 1'b0;
					held_nibble = 4'd0;
				end else begin
					decode_body(c);
				end
			end
			default: begin
				decode_body(c);
			end
		endcase
	endtask

	task automatic check_result(input hexparse_pkg::result_t got);
		hexparse_pkg::result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("result with none expected: kind %0d data %h",
				got.kind, m_tdata));
			return;
		end
		want = expected_results.pop_front();
		if (got.kind != want.kind)
			report_mismatch($sformatf("result_kind %0d, expected %0d", got.kind, want.kind));
		if (got.byte_value != want.byte_value)
			report_mismatch($sformatf("byte_value %h, expected %h",
				got.byte_value, want.byte_value));
		if (got.status != want.status)
			report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
		if (got.byte_count != want.byte_count)
			report_mismatch($sformatf("byte_count %0d, expected %0d",
				got.byte_count, want.byte_count));
		if (want.kind == hexparse_pkg::KIND_BYTE)
			bytes_seen++;
		else
			status_seen++;
	endtask

	// Result transfers are checked before the character of the same edge is
	// predicted; the parser cannot answer a character in the cycle it takes it.
	always @(posedge clk or negedge arst_n) begin : monitor
		hexparse_pkg::result_t got;
		if (!arst_n) begin
			clear_parse();
			byte_limit = 16'hFFFF;
			expected_results.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tuser, m_tdata[7:0], m_tdata[9:8], m_tdata[25:10]};
				check_result(got);
			end
			if (cfg_we)
				byte_limit = cfg_wdata;
			if (s_tvalid && s_tready)
				predict_transfer(s_tdata, s_tlast);
		end
		pending = expected_results.size();
	end

	// Anything still expected at the end is reported by the testbench top
	// through pending; it only gives the verdict once pending has drained.

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Hex text parser testbench
// Feeds hex strings, well formed and broken, through the parser under random
// idling on both streams and several byte limits; the checker module predicts
// and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS   = 200;
	localparam int HOLD_CYCLES   = 300;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] char_code
	logic        s_tlast;   // end_of_text
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [7:0] byte_value, [9:8] status, [25:10] byte_count
	logic        m_tuser;   // result_kind

	int          fail_count;
	int          pending;
	int          bytes_seen;
	int          status_seen;
	int          cycles;
	int          items_sent;
	int          strings_sent;
	int          hold_len;
	bit          gaps_on;
	bit          stalls_on;
	logic [7:0]  text_q[$];
	logic [15:0] limit_plan[5];

	hex_text_to_bytes_parser_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	hex_parse_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.fail_count  (fail_count),
		.pending     (pending),
		.bytes_seen  (bytes_seen),
		.status_seen (status_seen)
	);

	// 50 MHz clock.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Result side: random stall bursts, and one long hold-off on request.
	initial begin
		m_tready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				m_tready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
				m_tready <= 1'b1;
			end else if (stalls_on && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// One character transfer, with an occasional idle burst ahead of it.
	task automatic send_char(input logic [7:0] c, input logic last);
		if (gaps_on && $urandom_range(0, 9) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	// The queued text followed by its end transfer; the end character is noise.
	task automatic send_text();
		foreach (text_q[i])
			send_char(text_q[i], 1'b0);
		send_char(8'($urandom_range(0, 255)), 1'b1);
		strings_sent++;
	endtask

	task automatic load_text(input string s);
		text_q.delete();
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endtask

	// Stops sending until every predicted result has come out.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_limit(input logic [15:0] v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] digit_char(input logic [3:0] v);
		if (v < 4'd10)
			return hexparse_pkg::CH_ZERO + {4'd0, v};
		return ($urandom_range(0, 1) ? hexparse_pkg::CH_UPPER_A : hexparse_pkg::CH_LOWER_A)
			+ {4'd0, v} - hexparse_pkg::ALPHA_BASE;
	endfunction

	function automatic logic [7:0] delim_char();
		case ($urandom_range(0, 3))
			0: return hexparse_pkg::CH_COLON;
			1: return hexparse_pkg::CH_HYPHEN;
			2: return hexparse_pkg::CH_SPACE;
			default: return hexparse_pkg::CH_TAB + 8'($urandom_range(0, 4));
		endcase
	endfunction

	// Mostly well-formed hex text with random content; the rest is damaged.
	task automatic build_random_text();
		int         n_bytes;
		logic [7:0] b;
		n_bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
		text_q.delete();
		repeat ($urandom_range(0, 2))
			text_q.push_back(($urandom_range(0, 1)) ? hexparse_pkg::CH_SPACE
				: hexparse_pkg::CH_TAB + 8'($urandom_range(0, 4)));
		case ($urandom_range(0, 3))
			0: begin
				text_q.push_back(hexparse_pkg::CH_ZERO);
				text_q.push_back(hexparse_pkg::CH_LOWER_X);
			end
			1: begin
				text_q.push_back(hexparse_pkg::CH_ZERO);
				text_q.push_back(hexparse_pkg::CH_UPPER_X);
			end
			default: begin
			end
		endcase
		for (int i = 0; i < n_bytes; i++) begin
			b = 8'($urandom_range(0, 255));
			text_q.push_back(digit_char(b[7:4]));
			if ($urandom_range(0, 7) == 0)
				text_q.push_back(delim_char());
			text_q.push_back(digit_char(b[3:0]));
			if ($urandom_range(0, 3) == 0)
				text_q.push_back(delim_char());
		end
		if ($urandom_range(0, 4) != 0)
			return;
		case ($urandom_range(0, 3))
			0: text_q.insert($urandom_range(0, text_q.size()), 8'($urandom_range(0, 255)));
			1: begin
				if (text_q.size() > 0)
					text_q.delete($urandom_range(0, text_q.size() - 1));
			end
			2: begin
				text_q.delete();
				repeat ($urandom_range(1, 6))
					text_q.push_back(8'($urandom_range(0, 255)));
			end
			default: text_q.push_back(digit_char(4'($urandom_range(0, 15))));
		endcase
	endtask

	// Stimulus and verdict.
	initial begin
		int phase_end;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 16'd0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'd0;
		s_tlast <= 1'b0;
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		hold_len = 0;
		limit_plan = '{16'd3, 16'd0, 16'hFFFF, 16'($urandom_range(1, 40)), 16'd12};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings under the reset limit.
		load_text("  0XaB");   // leading blanks, upper prefix, mixed case digits
		text_q[1] = hexparse_pkg::CH_TAB;
		send_text();
		load_text("0");        // lone leading zero is an odd digit count
		send_text();
		load_text("07");       // leading zero without prefix is a high nibble
		send_text();
		load_text("g1");       // bad character, later digits ignored
		send_text();
		text_q = '{8'h00};     // NUL
		send_text();
		text_q = '{8'hFF};     // non-ASCII
		send_text();
		load_text("9F -");     // blank and delimiters in the body
		text_q[2] = hexparse_pkg::CH_CR - 8'd2;
		send_text();
		load_text("0x");       // prefix with no digits
		send_text();
		text_q.delete();       // empty string
		send_text();

		// Random strings under each byte limit; the last phase runs without idling.
		for (int p = 0; p < 5; p++) begin
			set_limit(limit_plan[p]);
			gaps_on = (p != 4);
			stalls_on = (p != 4);
			if (p == 2)
				hold_len = HOLD_CYCLES;
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				build_random_text();
				send_text();
				if ($urandom_range(0, 19) == 0)
					drain_results();
			end
		end

		drain_results();
		$display("Sent %0d strings in %0d transfers over byte limits 65535, %0d, %0d,",
			strings_sent, items_sent, limit_plan[0], limit_plan[1]);
		$display("%0d, %0d and %0d; checked %0d decoded bytes and %0d status results.",
			limit_plan[2], limit_plan[3], limit_plan[4], bytes_seen, status_seen);
		if (fail_count == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/hexparse_pkg.sv
hdl/hexparse_step.sv
hdl/hex_text_to_bytes_parser_unit.sv
test/hex_parse_checker.sv
test/tb.sv
